// File: rtl/core/piecewise_linear_interpolator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// implication checked every clock, off during reset
`define PLI_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, off during reset
`define PLI_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, status codes and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
package pli_pkg;
   localparam int MaxKeysDefault = 64;
   localparam int DataW          = 32;
   localparam int CountW         = 7;
   localparam int IndexW         = 6;
   localparam int ReqW           = 104;
   localparam int RspW           = 40;

   typedef enum logic [1:0] {
      ST_INTERP    = 2'd0,
      ST_CLAMP_LO  = 2'd1,
      ST_CLAMP_HI  = 2'd2,
      ST_HELD      = 2'd3
   } status_type;

   typedef enum logic {
      CMD_EVAL = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [IndexW-1:0]        idx;
      logic signed [DataW-1:0]  key;
      logic signed [DataW-1:0]  value;
      logic signed [DataW-1:0]  x;
   } job_type;
endpackage

// File: rtl/core/pli_front.sv
// ----------------------------------------------------------------------------
// Interpolator front end
// Accepts request transfers, unpacks them and queues them for the back end.
// ----------------------------------------------------------------------------
module pli_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [pli_pkg::ReqW-1:0] req_tdata, // entry_index,key,value,fraction
   input  logic                   req_tuser,    // cmd
   output logic                   job_valid,
   input  logic                   job_ready,
   output pli_pkg::job_type       job
);
   import pli_pkg::*;

   job_type     q_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign req_tready = (cnt_ff != 2'd2);
   assign job_valid  = (cnt_ff != 2'd0);
   assign job        = q_ff[rp_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = job_valid && job_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= '{cmd:   cmd_type'(req_tuser),
                          idx:   req_tdata[5:0],
                          key:   req_tdata[37:6],
                          value: req_tdata[69:38],
                          x:     req_tdata[101:70]};
      end
   end
endmodule

// File: rtl/core/pli_back.sv
// ----------------------------------------------------------------------------
// Interpolator back end
// Table memories, linear interval scan, bit-serial divide, multiply, output.
// ----------------------------------------------------------------------------
module pli_back #(
   parameter int MAX_KEYS = pli_pkg::MaxKeysDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [pli_pkg::CountW-1:0] key_count,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  pli_pkg::job_type       job,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [pli_pkg::RspW-1:0] rsp_tdata  // result_value, status
);
   import pli_pkg::*;

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int NW = $clog2(MAX_KEYS + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RD0   = 8'b00000010,
      S_RDN   = 8'b00000100,
      S_SCAN  = 8'b00001000,
      S_SCANW = 8'b00010000,
      S_DIV   = 8'b00100000,
      S_MUL   = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   logic signed [DataW-1:0] kmem [MAX_KEYS];
   logic signed [DataW-1:0] vmem [MAX_KEYS];
   logic signed [DataW-1:0] krd_ff, vrd_ff;
   logic [AW-1:0]           raddr;

   state_type               st_ff;
   logic [NW-1:0]           n_ff;
   logic [AW-1:0]           i_ff;
   logic signed [DataW-1:0] x_ff, k0_ff, v0_ff, last_ff;
   logic signed [DataW:0]   dk_ff, dv_ff;
   logic [48:0]             rem_ff;
   logic [48:0]             quo_ff;
   logic [5:0]              bit_ff;
   logic [47:0]             num_ff;
   logic signed [DataW+18:0] prod_ff;
   logic signed [DataW-1:0] res_ff;
   status_type              sts_ff;
   logic                    ov_ff;
   logic                    mulp_ff;
   logic [RspW-1:0]         out_ff;

   logic [NW-1:0]           n_cl;
   logic [49:0]             rem_sh;
   logic signed [DataW+1:0] sum;
   logic [16:0]             t;

   assign job_ready = st_ff == S_IDLE;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      n_cl = (32'(key_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count);
      raddr = i_ff;
      rem_sh = {rem_ff, num_ff[47]};
      t = (quo_ff > 49'd65536) ? 17'd65536 : quo_ff[16:0];
      sum = {{2{v0_ff[DataW-1]}}, v0_ff} + 34'(prod_ff >>> 16);
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready && job.cmd == CMD_LOAD && 32'(job.idx) < MAX_KEYS) begin
         kmem[AW'(job.idx)] <= job.key;
         vmem[AW'(job.idx)] <= job.value;
      end
      krd_ff <= kmem[raddr];
      vrd_ff <= vmem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         ov_ff   <= 1'b0;
         mulp_ff <= 1'b0;
         last_ff <= '0;
         out_ff  <= '0;
      end else begin
         if (ov_ff && rsp_tready && st_ff != S_OUT) ov_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (job_valid && job.cmd == CMD_EVAL) begin
               x_ff <= job.x;
               n_ff <= n_cl;
               i_ff <= '0;
               if (n_cl == '0) begin
                  res_ff <= last_ff; sts_ff <= ST_HELD; st_ff <= S_OUT;
               end else st_ff <= S_RD0;
            end
            S_RD0: begin
               i_ff <= AW'(n_ff - 1'b1);
               st_ff <= S_RDN;
            end
            S_RDN: begin
               if (x_ff < krd_ff) begin
                  res_ff <= vrd_ff; sts_ff <= ST_CLAMP_LO; st_ff <= S_OUT;
               end else begin
                  k0_ff <= krd_ff; v0_ff <= vrd_ff;
                  i_ff <= AW'(n_ff - 1'b1);
                  st_ff <= S_SCANW;
               end
            end
            S_SCANW: begin
               if (x_ff > krd_ff) begin
                  res_ff <= vrd_ff; sts_ff <= ST_CLAMP_HI; st_ff <= S_OUT;
               end else if (n_ff == NW'(1)) begin
                  res_ff <= last_ff; sts_ff <= ST_HELD; st_ff <= S_OUT;
               end else begin
                  i_ff <= AW'(1); st_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // registered table read: wait for each index's read data before comparing
               if (!mulp_ff) mulp_ff <= 1'b1;
               else begin
                  mulp_ff <= 1'b0;
                  if (x_ff <= krd_ff) begin
                     dk_ff <= {krd_ff[DataW-1], krd_ff} - {k0_ff[DataW-1], k0_ff};
                     dv_ff <= {vrd_ff[DataW-1], vrd_ff} - {v0_ff[DataW-1], v0_ff};
                     num_ff <= {16'(({x_ff[DataW-1], x_ff} - {k0_ff[DataW-1], k0_ff}) >> 16),
                                32'(({x_ff[DataW-1], x_ff} - {k0_ff[DataW-1], k0_ff}))} << 16;
                     rem_ff <= '0; quo_ff <= '0; bit_ff <= 6'd48;
                     if (krd_ff == k0_ff) begin
                        res_ff <= v0_ff; sts_ff <= ST_INTERP; st_ff <= S_OUT;
                     end else st_ff <= S_DIV;
                  end else begin
                     k0_ff <= krd_ff; v0_ff <= vrd_ff;
                     if (32'(i_ff) + 1 >= 32'(n_ff)) begin
                        res_ff <= last_ff; sts_ff <= ST_HELD; st_ff <= S_OUT;
                     end else i_ff <= i_ff + 1'b1;
                  end
               end
            end
            S_DIV: begin
               num_ff <= num_ff << 1;
               if (rem_sh >= 50'(dk_ff[DataW:0])) begin
                  rem_ff <= 49'(rem_sh - 50'(dk_ff[DataW:0]));
                  quo_ff <= {quo_ff[47:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[48:0];
                  quo_ff <= {quo_ff[47:0], 1'b0};
               end
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == 6'd1) st_ff <= S_MUL;
            end
            S_MUL: begin
               if (!mulp_ff) begin
                  prod_ff <= $signed({1'b0, t}) * dv_ff;
                  mulp_ff <= 1'b1;
               end else begin
                  mulp_ff <= 1'b0;
                  res_ff <= (sum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                            (sum < -34'sh80000000) ? -32'sh80000000 : sum[DataW-1:0];
                  sts_ff <= ST_INTERP;
                  st_ff <= S_OUT;
               end
            end
            S_OUT: if (!ov_ff || rsp_tready) begin
               ov_ff  <= 1'b1;
               out_ff <= {6'd0, sts_ff, res_ff};
               if (sts_ff != ST_HELD) last_ff <= res_ff;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/core/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator unit
// Breakpoint table loader and Q16.16 interpolator with saturation.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A load writes its key and value into the
// table as the back end takes it from the queue. An evaluate gives the last
// result for an empty table, clamps below the first key or above the last
// key, and else interpolates: the interval scan reads the table entries in
// turn from the key/value memory, then a 48-step bit-serial divider forms the
// weight and a multiply applies it. key_count counts as at most MAX_KEYS. A
// result waiting on the output register holds only the next answer, not the
// scan. A 2-entry queue decouples request intake from the back end.
module piecewise_linear_interpolator_unit #(
   parameter int MAX_KEYS = pli_pkg::MaxKeysDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pli_pkg::CountW-1:0]   csr_data,   // key_count
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // entry_index, entry_key, entry_value, fraction_in
   input  logic [pli_pkg::ReqW-1:0]     req_tdata,
   input  logic                         req_tuser,  // cmd
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [pli_pkg::RspW-1:0]     rsp_tdata   // result_value, status
);
   import pli_pkg::*;
   `include "piecewise_linear_interpolator_unit_assert.svh"

   logic [CountW-1:0] kc_ff;
   logic              job_valid, job_ready;
   job_type           job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) kc_ff <= '0;
      else if (csr_valid) kc_ff <= csr_data;
   end

   pli_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .job_valid, .job_ready, .job
   );

   pli_back #(.MAX_KEYS(MAX_KEYS)) u_back (
      .clock, .reset, .key_count(kc_ff), .job_valid, .job_ready, .job,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   `PLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
   `PLI_ASSERT_IMP(a_pad_zero, clock, reset, rsp_tvalid,
      rsp_tdata[RspW-1:34] == '0, "result padding not zero")
endmodule
